[sv/dre_pkg.sv]
// shared types and constants for the dns response address extractor
`default_nettype none

package dre_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int ADDR_W   = 64;
    localparam int TTL_W    = 32;
    localparam int COUNT_W  = 16;
    localparam int SKIP_W   = 8;
    localparam int FIELDS_W = 64;

    // header byte offsets
    localparam int HDR_QD_HI = 4;
    localparam int HDR_QD_LO = 5;
    localparam int HDR_AN_HI = 6;
    localparam int HDR_AN_LO = 7;
    localparam int HDR_LAST  = 11;

    // fixed field lengths
    localparam int QFIX_LEN   = 4;
    localparam int RRFIX_LEN  = 10;
    localparam int RDLEN_BYTES = 2;

    localparam logic [BYTE_W-1:0]  PTR_MASK    = 8'hc0;
    localparam logic [COUNT_W-1:0] RR_TYPE_A    = 16'h0001;
    localparam logic [COUNT_W-1:0] RR_TYPE_AAAA = 16'd28;
    localparam logic [COUNT_W-1:0] RR_CLASS_IN  = 16'h0001;
    localparam logic [COUNT_W-1:0] A_RDLEN      = 16'd4;
    localparam logic [COUNT_W-1:0] AAAA_RDLEN   = 16'd16;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_NAME   = 3'd1,
        PH_LABEL  = 3'd2,
        PH_PTR    = 3'd3,
        PH_QFIX   = 3'd4,
        PH_RRFIX  = 3'd5,
        PH_RDATA  = 3'd6,
        PH_DONE   = 3'd7
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_IPV4        = 3'd0,
        ST_IPV6        = 3'd1,
        ST_SHORT       = 3'd2,
        ST_NO_ANSWER   = 3'd3,
        ST_OVERRUN     = 3'd4,
        ST_UNSUPPORTED = 3'd5,
        ST_PENDING     = 3'd7
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              is_last;
    } byte_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr_high;
        logic [ADDR_W-1:0]   addr_low;
        logic [TTL_W-1:0]    time_to_live;
    } result_t;

endpackage

`default_nettype wire

[sv/dre_if.sv]
// byte input and result output channel interfaces
`default_nettype none

interface dre_in_if;
    import dre_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              is_last;

    modport source (output valid, output rx_byte, output is_last, input ready);
    modport sink   (input valid, input rx_byte, input is_last, output ready);
endinterface

interface dre_out_if;
    import dre_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr_high;
    logic [ADDR_W-1:0]   addr_low;
    logic [TTL_W-1:0]    time_to_live;

    modport source (output valid, output status, output addr_high, output addr_low,
                    output time_to_live, input ready);
    modport sink   (input valid, input status, input addr_high, input addr_low,
                    input time_to_live, output ready);
endinterface

`default_nettype wire

[sv/dns_response_address_extractor_top.sv]
// top level of the dns response address extractor
//
// Takes a DNS response one byte per transfer, is_last marking the final byte,
// and gives one result per message on the final byte: the address and TTL of
// the first answer when it is an A record (class IN, 4 bytes) or an AAAA
// record (16 bytes), or a failure code. Each byte sits in an input register,
// from which the parser updates its counters and phase, so a byte can be
// taken every cycle unless a final byte waits. The result goes into an
// output register; only a final byte waits while that register still holds
// an untaken result. Bytes at or past MAX_LEN are ignored except for is_last.
`default_nettype none

module dns_response_address_extractor_top #(
    parameter int MAX_LEN = 512
) (
    input  logic      clk,
    input  logic      rst_n,
    dre_in_if.sink    rx,
    dre_out_if.source res
);
    import dre_pkg::*;

    logic       stage_valid;
    byte_item_t stage_item;
    logic       advance;
    logic       res_free;
    logic       res_load;
    result_t    res_item;

    // a final byte moves on only when the result register can take its result
    assign advance = stage_valid && (!stage_item.is_last || res_free);

    dre_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    dre_parser #(
        .MAX_LEN (MAX_LEN)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (stage_item),
        .res_load (res_load),
        .res_item (res_item)
    );

    dre_out_stage u_out_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (res_load),
        .item  (res_item),
        .free  (res_free),
        .res   (res)
    );

endmodule

`default_nettype wire

[sv/dre_in_stage.sv]
// input register for the incoming message bytes
`default_nettype none

module dre_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    dre_in_if.sink              rx,
    input  logic                advance,
    output logic                stage_valid,
    output dre_pkg::byte_item_t stage_item
);
    import dre_pkg::*;

    logic       valid_reg;
    byte_item_t item_reg;

    assign rx.ready    = !valid_reg || advance;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            item_reg.rx_byte <= rx.rx_byte;
            item_reg.is_last <= rx.is_last;
        end
    end

endmodule

`default_nettype wire

[sv/dre_parser.sv]
// per-byte message parser: header counts, name skipping, record fields, address
`default_nettype none

module dre_parser #(
    parameter int MAX_LEN = 512
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  dre_pkg::byte_item_t item,
    output logic                res_load,
    output dre_pkg::result_t    res_item
);
    import dre_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN + 1);

    logic [POS_W-1:0]    pos_reg, pos_next;
    phase_t              phase_reg, phase_next, phase_upd;
    logic [COUNT_W-1:0]  an_reg, an_next, an_upd;
    logic [COUNT_W-1:0]  qleft_reg, qleft_next, qleft_upd;
    logic [SKIP_W-1:0]   skip_reg, skip_next, skip_upd;
    logic [FIELDS_W-1:0] rf_reg, rf_next, rf_upd;
    logic [COUNT_W-1:0]  dl_reg, dl_next, dl_upd;
    logic [2*ADDR_W-1:0] acc_reg, acc_next, acc_upd;
    status_t             verdict_reg, verdict_next, verdict_upd;

    logic [BYTE_W-1:0]  b;
    logic               in_range;
    logic [COUNT_W-1:0] rtype, rclass;

    assign b        = item.rx_byte;
    assign in_range = pos_reg < POS_W'(MAX_LEN);
    assign res_load = advance && item.is_last;

    always_comb
    begin
        phase_upd   = phase_reg;
        an_upd      = an_reg;
        qleft_upd   = qleft_reg;
        skip_upd    = skip_reg;
        rf_upd      = rf_reg;
        dl_upd      = dl_reg;
        acc_upd     = acc_reg;
        verdict_upd = verdict_reg;
        rtype       = rf_reg[63:48];
        rclass      = rf_reg[47:32];

        if (in_range)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg == POS_W'(HDR_QD_HI))
                        qleft_upd = {b, qleft_reg[BYTE_W-1:0]};
                    else if (pos_reg == POS_W'(HDR_QD_LO))
                        qleft_upd = {qleft_reg[COUNT_W-1:BYTE_W], b};
                    else if (pos_reg == POS_W'(HDR_AN_HI))
                        an_upd = {b, an_reg[BYTE_W-1:0]};
                    else if (pos_reg == POS_W'(HDR_AN_LO))
                        an_upd = {an_reg[COUNT_W-1:BYTE_W], b};
                    if (pos_reg == POS_W'(HDR_LAST))
                    begin
                        if (an_reg == '0)
                        begin
                            verdict_upd = ST_NO_ANSWER;
                            phase_upd   = PH_DONE;
                        end
                        else
                        begin
                            phase_upd = PH_NAME;
                        end
                    end
                end
                PH_NAME, PH_PTR:
                begin
                    // a zero byte or the second pointer byte ends the name
                    if ((phase_reg == PH_PTR) || (b == '0))
                    begin
                        if (qleft_reg != '0)
                        begin
                            phase_upd = PH_QFIX;
                            skip_upd  = SKIP_W'(QFIX_LEN);
                        end
                        else
                        begin
                            phase_upd = PH_RRFIX;
                            skip_upd  = SKIP_W'(RRFIX_LEN);
                            rf_upd    = '0;
                            dl_upd    = '0;
                        end
                    end
                    else if ((b & PTR_MASK) == PTR_MASK)
                    begin
                        phase_upd = PH_PTR;
                    end
                    else
                    begin
                        skip_upd  = b;
                        phase_upd = PH_LABEL;
                    end
                end
                PH_LABEL:
                begin
                    skip_upd = skip_reg - 1'b1;
                    if (skip_upd == '0)
                        phase_upd = PH_NAME;
                end
                PH_QFIX:
                begin
                    skip_upd = skip_reg - 1'b1;
                    if (skip_upd == '0)
                    begin
                        qleft_upd = qleft_reg - 1'b1;
                        phase_upd = PH_NAME;
                    end
                end
                PH_RRFIX:
                begin
                    if (skip_reg > SKIP_W'(RDLEN_BYTES))
                        rf_upd = {rf_reg[FIELDS_W-BYTE_W-1:0], b};
                    else
                        dl_upd = {dl_reg[COUNT_W-BYTE_W-1:0], b};
                    skip_upd = skip_reg - 1'b1;
                    if (skip_upd == '0)
                    begin
                        // type and class are complete before the length bytes
                        if ((rtype == RR_TYPE_A) && (rclass == RR_CLASS_IN)
                            && (dl_upd == A_RDLEN))
                            verdict_upd = ST_IPV4;
                        else if ((rtype == RR_TYPE_AAAA) && (dl_upd == AAAA_RDLEN))
                            verdict_upd = ST_IPV6;
                        else
                            verdict_upd = ST_UNSUPPORTED;
                        phase_upd = (dl_upd == '0) ? PH_DONE : PH_RDATA;
                    end
                end
                PH_RDATA:
                begin
                    acc_upd = {acc_reg[2*ADDR_W-BYTE_W-1:0], b};
                    dl_upd  = dl_reg - 1'b1;
                    if (dl_upd == '0)
                        phase_upd = PH_DONE;
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // result is formed from the state after the last byte has been taken
    always_comb
    begin
        res_item = '0;
        unique case (phase_upd)
            PH_DONE:
            begin
                res_item.status = verdict_upd;
                if (verdict_upd == ST_IPV4)
                begin
                    res_item.addr_low     = {32'd0, acc_upd[31:0]};
                    res_item.time_to_live = rf_upd[TTL_W-1:0];
                end
                else if (verdict_upd == ST_IPV6)
                begin
                    res_item.addr_high    = acc_upd[2*ADDR_W-1:ADDR_W];
                    res_item.addr_low     = acc_upd[ADDR_W-1:0];
                    res_item.time_to_live = rf_upd[TTL_W-1:0];
                end
            end
            PH_HEADER:
                res_item.status = ST_SHORT;
            default:
                res_item.status = ST_OVERRUN;
        endcase
    end

    always_comb
    begin
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        an_next      = an_reg;
        qleft_next   = qleft_reg;
        skip_next    = skip_reg;
        rf_next      = rf_reg;
        dl_next      = dl_reg;
        acc_next     = acc_reg;
        verdict_next = verdict_reg;
        if (advance)
        begin
            if (item.is_last)
            begin
                pos_next     = '0;
                phase_next   = PH_HEADER;
                an_next      = '0;
                qleft_next   = '0;
                skip_next    = '0;
                rf_next      = '0;
                dl_next      = '0;
                acc_next     = '0;
                verdict_next = ST_PENDING;
            end
            else
            begin
                pos_next     = in_range ? pos_reg + 1'b1 : pos_reg;
                phase_next   = phase_upd;
                an_next      = an_upd;
                qleft_next   = qleft_upd;
                skip_next    = skip_upd;
                rf_next      = rf_upd;
                dl_next      = dl_upd;
                acc_next     = acc_upd;
                verdict_next = verdict_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= PH_HEADER;
            an_reg      <= '0;
            qleft_reg   <= '0;
            skip_reg    <= '0;
            rf_reg      <= '0;
            dl_reg      <= '0;
            acc_reg     <= '0;
            verdict_reg <= ST_PENDING;
        end
        else
        begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            an_reg      <= an_next;
            qleft_reg   <= qleft_next;
            skip_reg    <= skip_next;
            rf_reg      <= rf_next;
            dl_reg      <= dl_next;
            acc_reg     <= acc_next;
            verdict_reg <= verdict_next;
        end
    end

endmodule

`default_nettype wire

[sv/dre_out_stage.sv]
// result register driving the output channel
`default_nettype none

module dre_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  dre_pkg::result_t item,
    output logic             free,
    dre_out_if.source        res
);
    import dre_pkg::*;

    logic    valid_reg;
    result_t item_reg;

    assign free             = !valid_reg || res.ready;
    assign res.valid        = valid_reg;
    assign res.status       = item_reg.status;
    assign res.addr_high    = item_reg.addr_high;
    assign res.addr_low     = item_reg.addr_low;
    assign res.time_to_live = item_reg.time_to_live;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

endmodule

`default_nettype wire
